/* hw/rtl/csvtok_pkg.sv */
// Shared types and constants for the CSV field tokenizer.
`timescale 1ns / 1ps

package csvtok_pkg;

  // Input command codes.
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOI  = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SEPARATOR = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_QUOTE     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NEWLINE   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] SEPARATOR_RESET = 8'd44;
  localparam logic [7:0] QUOTE_RESET     = 8'd34;
  localparam logic [7:0] NEWLINE_RESET   = 8'd10;

  // Parser modes, one-hot.
  typedef enum logic [4:0] {
    MODE_BETWEEN = 5'b00001,
    MODE_PLAIN   = 5'b00010,
    MODE_QUOTED  = 5'b00100,
    MODE_QSEEN   = 5'b01000,
    MODE_HALTED  = 5'b10000
  } mode_t;

  // One input item.
  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       field_end;
    logic       line_end;
    logic       parse_error;
  } out_item_t;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    mode_t mode;
    logic  field_has_chars;
    logic  line_has_fields;
  } parse_state_t;

  // Active delimiter bytes.
  typedef struct packed {
    logic [7:0] separator_byte;
    logic [7:0] quote_byte;
    logic [7:0] newline_byte;
  } delim_cfg_t;

  // Outcome of one parser step.
  typedef struct packed {
    parse_state_t state;
    logic         has_result;
    out_item_t    result;
  } step_out_t;

endpackage

/* hw/rtl/csv_field_tokenizer.sv */
// Top level of the byte-serial CSV field tokenizer.
`timescale 1ns / 1ps

// The tokenizer takes one byte (or an end-of-input mark) per cycle and keeps
// that rate as long as results are taken: each item is registered, parsed
// combinationally by the mode decoder, and its result (if any) is written to a
// two-entry output queue, so a result is offered once its item has left the
// input register and been written to the queue. The parser state update as each
// held item advances sets the one-item-per-cycle rate. Delimiter registers may
// be changed only while the block is idle.
module csv_field_tokenizer import csvtok_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  in_item_t               item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output out_item_t              result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data
);

  delim_cfg_t   delims;
  parse_state_t state;
  in_item_t     held_item;
  logic         held_valid;
  step_out_t    step;
  logic         q_space;
  logic         advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      delims.separator_byte <= SEPARATOR_RESET;
      delims.quote_byte     <= QUOTE_RESET;
      delims.newline_byte   <= NEWLINE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEPARATOR: delims.separator_byte <= cfg_data;
        REG_QUOTE:     delims.quote_byte     <= cfg_data;
        REG_NEWLINE:   delims.newline_byte   <= cfg_data;
        default:       delims                <= delims;
      endcase
    end
  end

  // The held item moves on when its result has room or it yields none.
  assign advance    = held_valid & (~step.has_result | q_space);
  assign item_ready = ~held_valid | advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready & item_valid) begin
      held_item <= item;
    end
  end

  // Parser state, updated when the held item completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode            <= MODE_BETWEEN;
      state.field_has_chars <= 1'b0;
      state.line_has_fields <= 1'b0;
    end else if (advance) begin
      state <= step.state;
    end
  end

  csvtok_step u_step (
    .state  (state),
    .delims (delims),
    .item   (held_item),
    .step   (step)
  );

  csvtok_out_queue u_out_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (advance & step.has_result),
    .push_data    (step.result),
    .has_space    (q_space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

/* hw/rtl/csvtok_step.sv */
// Combinational next-state and result logic for one tokenizer step.
`timescale 1ns / 1ps

module csvtok_step import csvtok_pkg::*; (
  input  parse_state_t state,
  input  delim_cfg_t   delims,
  input  in_item_t     item,
  output step_out_t    step
);

  // Close the open field, and the line too when also_line is set.
  function automatic step_out_t close_field(parse_state_t cur, logic also_line);
    step_out_t s;
    logic      fe;
    logic      lhf;
    logic      le;
    fe  = cur.field_has_chars;
    lhf = cur.line_has_fields | fe;
    le  = also_line & lhf;
    s = '0;
    s.state.mode            = MODE_BETWEEN;
    s.state.field_has_chars = 1'b0;
    s.state.line_has_fields = also_line ? 1'b0 : lhf;
    s.has_result            = fe | le;
    s.result.field_end      = fe;
    s.result.line_end       = le;
    return s;
  endfunction

  // Emit one content byte of the open field.
  function automatic step_out_t emit_char(parse_state_t cur, mode_t mode, logic [7:0] ch);
    step_out_t s;
    s = '0;
    s.state                 = cur;
    s.state.mode            = mode;
    s.state.field_has_chars = 1'b1;
    s.has_result            = 1'b1;
    s.result.out_char       = ch;
    s.result.char_valid     = 1'b1;
    return s;
  endfunction

  // Report malformed quoting and stop.
  function automatic step_out_t raise_error(parse_state_t cur);
    step_out_t s;
    s = '0;
    s.state              = cur;
    s.state.mode         = MODE_HALTED;
    s.has_result         = 1'b1;
    s.result.parse_error = 1'b1;
    return s;
  endfunction

  logic is_quote;
  logic is_newline;
  logic is_sep;

  // Byte classification against the active delimiters.
  assign is_quote   = (item.in_byte == delims.quote_byte);
  assign is_newline = (item.in_byte == delims.newline_byte);
  assign is_sep     = (item.in_byte == delims.separator_byte);

  // Mode decode; priority among coinciding delimiters follows the if order.
  always_comb begin
    step = '0;
    step.state = state;
    if (state.mode == MODE_HALTED) begin
      step.state = state;
    end else if (item.cmd == CMD_EOI) begin
      if (state.mode == MODE_QUOTED) begin
        step = raise_error(state);
      end else begin
        step = close_field(state, 1'b1);
      end
    end else begin
      case (state.mode)
        MODE_BETWEEN: begin
          if (is_quote) begin
            step.state.mode = MODE_QUOTED;
          end else if (is_newline) begin
            step = close_field(state, 1'b1);
          end else if (is_sep) begin
            step = close_field(state, 1'b0);
          end else begin
            step = emit_char(state, MODE_PLAIN, item.in_byte);
          end
        end
        MODE_PLAIN: begin
          if (is_newline) begin
            step = close_field(state, 1'b1);
          end else if (is_sep) begin
            step = close_field(state, 1'b0);
          end else begin
            step = emit_char(state, MODE_PLAIN, item.in_byte);
          end
        end
        MODE_QUOTED: begin
          if (is_quote) begin
            step.state.mode = MODE_QSEEN;
          end else begin
            step = emit_char(state, MODE_QUOTED, item.in_byte);
          end
        end
        MODE_QSEEN: begin
          if (is_quote) begin
            step = emit_char(state, MODE_QUOTED, item.in_byte);
          end else if (is_newline) begin
            step = close_field(state, 1'b1);
          end else if (is_sep) begin
            step = close_field(state, 1'b0);
          end else begin
            step = raise_error(state);
          end
        end
        default: begin
          // Unknown mode codes stop the parser silently.
          step.state.mode = MODE_HALTED;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/csvtok_out_queue.sv */
// Two-entry result queue that decouples the parser from the consumer.
`timescale 1ns / 1ps

module csvtok_out_queue import csvtok_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_data,
  output logic      has_space,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  out_item_t   slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign pop          = result_valid & result_ready;
  assign has_space    = (count != 2'd2);
  assign result_valid = (count != 2'd0);
  assign result       = slots[rd_ptr];

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* tb/csv_field_tokenizer_checker.sv */
// Checker for the CSV field tokenizer: predicts each token and compares it with the block.
`timescale 1ns / 1ps

module csv_field_tokenizer_checker import csvtok_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic                   item_ready,
  input  in_item_t               item,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  out_item_t              result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data,
  output int                     fail_count,
  output int                     pending
);

  // Predicted parser state and the delimiter bytes in force.
  mode_t      tok_mode;
  logic       field_chars;
  logic       line_fields;
  delim_cfg_t delims;

  // Tokens predicted but not yet seen on the result channel, oldest first.
  out_item_t  pending_tokens[$];

  // Append one predicted token behind the ones already waiting.
  task automatic queue_token(input out_item_t tok);
    pending_tokens.insert(pending_tokens.size(), tok);
  endtask

  // A content byte leaves the current field non-empty.
  function automatic bit emit_char(input logic [7:0] ch, output out_item_t res);
    field_chars = 1'b1;
    res = '0;
    res.out_char = ch;
    res.char_valid = 1'b1;
    return 1'b1;
  endfunction

  // Closing a field marks it only if it held content; a line only if it held a field.
  function automatic bit close_field(input bit also_line, output out_item_t res);
    bit fe;
    bit le;
    fe = field_chars;
    if (fe) begin
      line_fields = 1'b1;
    end
    le = also_line && line_fields;
    field_chars = 1'b0;
    if (also_line) begin
      line_fields = 1'b0;
    end
    tok_mode = MODE_BETWEEN;
    res = '0;
    res.field_end = fe;
    res.line_end = le;
    return fe || le;
  endfunction

  // The error is reported once and the parser stays halted.
  function automatic bit raise_error(output out_item_t res);
    tok_mode = MODE_HALTED;
    res = '0;
    res.parse_error = 1'b1;
    return 1'b1;
  endfunction

  // Advance the predicted parser by one input item; returns 1 when a token results.
  function automatic bit tokenize(input in_item_t it, output out_item_t res);
    logic [7:0] b;
    b = it.in_byte;
    res = '0;
    if (tok_mode == MODE_HALTED) begin
      return 1'b0;
    end
    if (it.cmd == CMD_EOI) begin
      if (tok_mode == MODE_QUOTED) begin
        return raise_error(res);
      end
      return close_field(1'b1, res);
    end
    case (tok_mode)
      MODE_BETWEEN: begin
        if (b == delims.quote_byte) begin
          tok_mode = MODE_QUOTED;
          return 1'b0;
        end
        if (b == delims.newline_byte) return close_field(1'b1, res);
        if (b == delims.separator_byte) return close_field(1'b0, res);
        tok_mode = MODE_PLAIN;
        return emit_char(b, res);
      end
      MODE_PLAIN: begin
        if (b == delims.newline_byte) return close_field(1'b1, res);
        if (b == delims.separator_byte) return close_field(1'b0, res);
        return emit_char(b, res);
      end
      MODE_QUOTED: begin
        if (b == delims.quote_byte) begin
          tok_mode = MODE_QSEEN;
          return 1'b0;
        end
        return emit_char(b, res);
      end
      MODE_QSEEN: begin
        if (b == delims.quote_byte) begin
          tok_mode = MODE_QUOTED;
          return emit_char(b, res);
        end
        if (b == delims.newline_byte) return close_field(1'b1, res);
        if (b == delims.separator_byte) return close_field(1'b0, res);
        return raise_error(res);
      end
      default: begin
        tok_mode = MODE_HALTED;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic note_mismatch(input string name, input int want, input int got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    fail_count++;
  endtask

  // Sample both channels and the register port at every rising edge.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t next_token;
    if (rst) begin
      tok_mode = MODE_BETWEEN;
      field_chars = 1'b0;
      line_fields = 1'b0;
      delims.separator_byte = SEPARATOR_RESET;
      delims.quote_byte = QUOTE_RESET;
      delims.newline_byte = NEWLINE_RESET;
      pending_tokens.delete();
      fail_count = 0;
    end else begin
      // A result transfer is matched against the oldest predicted token.
      if (result_valid && result_ready) begin
        if (pending_tokens.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, result);
          fail_count++;
        end else begin
          want = pending_tokens.pop_front();
          if (result.out_char !== want.out_char)
            note_mismatch("out_char", want.out_char, result.out_char);
          if (result.char_valid !== want.char_valid)
            note_mismatch("char_valid", want.char_valid, result.char_valid);
          if (result.field_end !== want.field_end)
            note_mismatch("field_end", want.field_end, result.field_end);
          if (result.line_end !== want.line_end)
            note_mismatch("line_end", want.line_end, result.line_end);
          if (result.parse_error !== want.parse_error)
            note_mismatch("parse_error", want.parse_error, result.parse_error);
        end
      end

      // An input transfer may add one predicted token.
      if (item_valid && item_ready) begin
        if (tokenize(item, next_token)) begin
          queue_token(next_token);
        end
      end

      // Mirror the delimiter register writes.
      if (cfg_we) begin
        case (cfg_index)
          REG_SEPARATOR: delims.separator_byte = cfg_data;
          REG_QUOTE:     delims.quote_byte = cfg_data;
          REG_NEWLINE:   delims.newline_byte = cfg_data;
          default: ;
        endcase
      end
    end
    pending <= pending_tokens.size();
  end

endmodule

/* tb/csv_field_tokenizer_tb.sv */
// Testbench top for the CSV field tokenizer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module csv_field_tokenizer_tb;
  import csvtok_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_ready;
  in_item_t               item = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  out_item_t              result;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_SEPARATOR;
  logic [7:0]             cfg_data = '0;

  int fail_count;
  int pending;
  int cycles = 0;
  int items_sent = 0;
  bit idle_en = 1'b1;

  // Delimiter bytes currently programmed, used to shape the byte stream.
  logic [7:0] cur_sep = SEPARATOR_RESET;
  logic [7:0] cur_quote = QUOTE_RESET;
  logic [7:0] cur_nl = NEWLINE_RESET;

  csv_field_tokenizer dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  csv_field_tokenizer_checker field_check (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver stalls at random while idling is enabled.
  always @(posedge clk) begin
    if (idle_en) begin
      result_ready <= ($urandom_range(99) >= 35);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Offer one item, with an optional random gap first, and hold it until the transfer.
  task automatic push_item(input in_item_t it);
    while (idle_en && $urandom_range(99) < 35) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    push_item('{cmd: CMD_DATA, in_byte: b});
  endtask

  task automatic send_eoi();
    push_item('{cmd: CMD_EOI, in_byte: 8'($urandom_range(255))});
  endtask

  // A random byte that is none of the three delimiters.
  function automatic logic [7:0] ordinary_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == cur_sep || b == cur_quote || b == cur_nl);
    return b;
  endfunction

  // Wait until every predicted token has arrived and the pipeline has emptied.
  task automatic wait_drained();
    item_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Program all three delimiter registers while the block is idle.
  task automatic set_delims(input logic [7:0] sep, input logic [7:0] quo,
                            input logic [7:0] nl);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= REG_SEPARATOR;
    cfg_data <= sep;
    @(posedge clk);
    cfg_index <= REG_QUOTE;
    cfg_data <= quo;
    @(posedge clk);
    cfg_index <= REG_NEWLINE;
    cfg_data <= nl;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_sep = sep;
    cur_quote = quo;
    cur_nl = nl;
  endtask

  // One record: mostly well-formed fields with random content, sometimes loose noise.
  // A delimiter that equals the quote byte cannot end a quoted or empty field, so it is avoided.
  task automatic send_record();
    int nfields;
    int kind;
    int len;
    bit sep_ok;
    bit nl_ok;
    logic [7:0] b;
    sep_ok = (cur_sep != cur_quote);
    nl_ok = (cur_nl != cur_quote);
    if ($urandom_range(9) == 0) begin
      // Noise: any byte but the quote, so no quoted field can open.
      len = $urandom_range(12);
      repeat (len) begin
        b = 8'($urandom_range(255));
        if (b != cur_quote) send_byte(b);
      end
    end else begin
      nfields = $urandom_range(4);
      for (int f = 0; f < nfields; f++) begin
        if (f > 0) begin
          if (sep_ok) send_byte(cur_sep);
          else if (nl_ok) send_byte(cur_nl);
          else send_eoi();
        end
        kind = $urandom_range(9);
        if (kind < 5) begin
          // Plain field, possibly empty, with an occasional quote as content.
          len = (kind == 0) ? 0 : $urandom_range(1, 8);
          for (int i = 0; i < len; i++) begin
            send_byte((i > 0 && $urandom_range(7) == 0) ? cur_quote : ordinary_byte());
          end
        end else begin
          // Quoted field holding delimiters and doubled quotes.
          send_byte(cur_quote);
          len = $urandom_range(6);
          repeat (len) begin
            case ($urandom_range(5))
              0: begin
                send_byte(cur_quote);
                send_byte(cur_quote);
              end
              1: send_byte(sep_ok ? cur_sep : ordinary_byte());
              2: send_byte(nl_ok ? cur_nl : ordinary_byte());
              default: send_byte(ordinary_byte());
            endcase
          end
          send_byte(cur_quote);
        end
      end
    end
    if (nl_ok && $urandom_range(7) != 0) send_byte(cur_nl);
    else send_eoi();
  endtask

  // Random records under one delimiter setting, closed by an end of input.
  task automatic run_phase(input logic [7:0] sep, input logic [7:0] quo,
                           input logic [7:0] nl, input int count, input bit idle);
    int start;
    set_delims(sep, quo, nl);
    idle_en = idle;
    start = items_sent;
    while (items_sent - start < count) send_record();
    send_eoi();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset delimiters.
    // Extreme bytes and a quote as content of a plain field, then an empty field.
    send_byte(8'h00); send_byte(8'hff); send_byte(QUOTE_RESET);
    send_byte(SEPARATOR_RESET); send_byte(SEPARATOR_RESET);
    // Quoted field with a separator, a newline and a doubled quote inside.
    send_byte(QUOTE_RESET); send_byte(SEPARATOR_RESET); send_byte(NEWLINE_RESET);
    send_byte(QUOTE_RESET); send_byte(QUOTE_RESET); send_byte(QUOTE_RESET);
    send_byte(NEWLINE_RESET);
    // Empty line, line of empty fields, empty quoted field.
    send_byte(NEWLINE_RESET); send_byte(SEPARATOR_RESET); send_byte(NEWLINE_RESET);
    send_byte(QUOTE_RESET); send_byte(QUOTE_RESET); send_byte(SEPARATOR_RESET);
    // End of input in a plain field, after a closing quote, and on an empty line.
    send_byte("x"); send_byte(QUOTE_RESET); send_eoi();
    send_byte(QUOTE_RESET); send_byte("y"); send_byte(QUOTE_RESET); send_eoi();
    send_eoi();

    // Random part over several delimiter settings.
    idle_en = 1'b1;
    begin
      int start;
      start = items_sent;
      while (items_sent - start < 400) send_record();
      send_eoi();
    end
    run_phase(8'h00, 8'hff, 8'h80, 300, 1'b1);
    // Long stretch with both sides always ready.
    run_phase(8'hff, 8'h00, 8'h01, 300, 1'b0);
    // Separator equal to newline.
    run_phase(8'd59, 8'd39, 8'd59, 250, 1'b1);
    // Quote equal to newline, then quote equal to separator.
    run_phase(8'd9, 8'd13, 8'd13, 150, 1'b1);
    run_phase(8'd124, 8'd124, 8'd10, 150, 1'b1);
    run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 200, 1'b1);

    // Malformed quoting halts the parser for the rest of the run.
    send_byte(cur_quote);
    send_byte(ordinary_byte());
    if ($urandom_range(1) == 0) begin
      // Stray byte after a closing quote.
      send_byte(cur_quote);
      send_byte(ordinary_byte());
    end else begin
      // Quoted field left open at end of input.
      send_eoi();
    end
    // Nothing may come out once halted, end of input included.
    send_byte(cur_quote); send_byte(ordinary_byte()); send_eoi();
    send_byte(8'($urandom_range(255))); send_byte(cur_nl); send_eoi();

    wait_drained();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/csvtok_pkg.sv
hw/rtl/csvtok_step.sv
hw/rtl/csvtok_out_queue.sv
hw/rtl/csv_field_tokenizer.sv
tb/csv_field_tokenizer_checker.sv
tb/csv_field_tokenizer_tb.sv
